// File: rtl/gfsm_pkg.sv
// Types and constants shared by the guarded state machine manager.
`timescale 1ns / 1ps
package gfsm_pkg;

	localparam int IDX_W   = 4;
	localparam int SLOTS   = 16;
	localparam int CNT_W   = 5;
	localparam int CFG_A_W = 3;
	localparam int CFG_D_W = 64;

	typedef enum logic [1:0] {
		OP_ACTIVATE = 2'd0,
		OP_REQUEST  = 2'd1,
		OP_RESTART  = 2'd2
	} gfsm_op_t;

	typedef enum logic [2:0] {
		EV_NONE            = 3'd0,
		EV_TRANSITION      = 3'd1,
		EV_ALL_DISABLED    = 3'd2,
		EV_TARGET_DISABLED = 3'd3,
		EV_EXIT_REFUSED    = 3'd4,
		EV_ENTRY_REFUSED   = 3'd5,
		EV_ILLEGAL         = 3'd6,
		EV_NOT_STARTED     = 3'd7
	} gfsm_event_t;

	localparam logic [CFG_A_W-1:0] CFG_STATE_COUNT   = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_GLOBAL_ENABLE = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_TARGET_ENABLE = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_SUCC_TABLE    = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_SUCC_PRESENT  = 3'd4;

	typedef struct packed {
		gfsm_op_t           operation;
		logic [IDX_W-1:0]   target_state;
		logic               current_finished;
		logic               current_exit_ok;
		logic [SLOTS-1:0]   entry_ok_mask;
	} gfsm_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   present_state;
		logic               started;
		logic               pending_valid;
		logic [IDX_W-1:0]   pending_target;
	} gfsm_ctx_t;

	typedef struct packed {
		logic               global_enable;
		logic [SLOTS-1:0]   target_enable_mask;
		logic [CFG_D_W-1:0] successor_table;
		logic [SLOTS-1:0]   successor_present_mask;
	} gfsm_cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]   current_index;
		gfsm_event_t        event_code;
		logic               exit_pulse;
		logic               init_pulse;
		logic               continue_pulse;
		logic               request_pending;
	} gfsm_result_t;

endpackage

// File: rtl/gfsm_step.sv
// Decision logic for one item: guard checks, next context and result.
`timescale 1ns / 1ps
module gfsm_step import gfsm_pkg::*; (
	input  gfsm_item_t       item,
	input  gfsm_ctx_t        ctx,
	input  gfsm_cfg_t        cfg,
	input  logic [CNT_W-1:0] n_used,
	output gfsm_ctx_t        ctx_next,
	output gfsm_result_t     result,
	output logic             restart
);

	logic             try_en;
	logic [IDX_W-1:0] try_tgt;
	gfsm_event_t      try_ev;
	logic [IDX_W-1:0] succ;
	gfsm_event_t      ev;
	logic             exit_p;
	logic             init_p;
	logic             cont_p;

	assign succ = cfg.successor_table[ctx.present_state*IDX_W +: IDX_W];

	// Guard checks in priority order; the first failure names the event
	always_comb begin
		if ({1'b0, try_tgt} >= n_used) begin
			try_ev = EV_ILLEGAL;
		end else if (!cfg.global_enable) begin
			try_ev = EV_ALL_DISABLED;
		end else if (!cfg.target_enable_mask[try_tgt]) begin
			try_ev = EV_TARGET_DISABLED;
		end else if (!item.current_exit_ok) begin
			try_ev = EV_EXIT_REFUSED;
		end else if (!item.entry_ok_mask[try_tgt]) begin
			try_ev = EV_ENTRY_REFUSED;
		end else begin
			try_ev = EV_TRANSITION;
		end
	end

	always_comb begin
		try_en   = 1'b0;
		try_tgt  = ctx.pending_target;
		ctx_next = ctx;
		ev       = EV_NONE;
		exit_p   = 1'b0;
		init_p   = 1'b0;
		cont_p   = 1'b0;
		restart  = 1'b0;
		unique case (item.operation)
			OP_RESTART: begin
				exit_p                 = ctx.started;
				init_p                 = 1'b1;
				restart                = 1'b1;
				ctx_next.present_state = '0;
				ctx_next.started       = 1'b1;
			end
			OP_REQUEST: begin
				if (!ctx.started) begin
					ev = EV_NOT_STARTED;
				end else if ({1'b0, item.target_state} >= n_used) begin
					ev = EV_ILLEGAL;
				end else begin
					ctx_next.pending_target = item.target_state;
					ctx_next.pending_valid  = 1'b1;
				end
			end
			OP_ACTIVATE: begin
				if (!ctx.started) begin
					ev = EV_NOT_STARTED;
				end else begin
					cont_p = 1'b1;
					if (ctx.pending_valid) begin
						try_en                 = 1'b1;
						ctx_next.pending_valid = 1'b0;
					end else if (item.current_finished &&
						     cfg.successor_present_mask[ctx.present_state]) begin
						try_en  = 1'b1;
						try_tgt = succ;
					end
					if (try_en) begin
						ev = try_ev;
						if (try_ev == EV_TRANSITION) begin
							exit_p                 = 1'b1;
							init_p                 = 1'b1;
							ctx_next.present_state = try_tgt;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result.current_index   = ctx_next.present_state;
	assign result.event_code      = ev;
	assign result.exit_pulse      = exit_p;
	assign result.init_pulse      = init_p;
	assign result.continue_pulse  = cont_p;
	assign result.request_pending = ctx_next.pending_valid;

endmodule

// File: rtl/guarded_fsm_transition_manager_top.sv
// Top level of the guarded state machine manager: channels, registers, state.
//
// Usage:
//   Items enter on the s_ channel: s_tuser carries the operation (activate,
//   request, restart), s_tdata the target, the state flags and the entry mask.
//   Every item gives exactly one result on the m_ channel, in order.
//   Settings are written through cfg_we/cfg_addr/cfg_wdata while no item is in
//   flight; a write takes effect at the same clock edge.
//   An accepted item is held in the input register until its result is loaded
//   into the result register behind m_tvalid. Throughput: one item per cycle
//   unless the receiver stalls; the decision is one pass through the guard
//   checks and the successor table mux between the input and result registers.
//   When the receiver stalls the result register holds, the input register
//   takes one more item, and s_tready falls only when both are full.
//   Reset (arst_n low) empties both registers, clears the current state,
//   the started flag and any pending request, and loads the default settings.
//   Before the first restart item, activate and request items report
//   "not started" and change nothing.
`timescale 1ns / 1ps
module guarded_fsm_transition_manager_top import gfsm_pkg::*; #(
	parameter int MAX_STATES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// [3:0] target_state, [4] current_finished, [5] current_exit_ok,
	// [21:6] entry_ok_mask, [23:22] zero
	input  logic [23:0]        s_tdata,
	// [1:0] operation
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [3:0] current_index, [6:4] event_code, [7] exit_pulse, [8] init_pulse,
	// [9] continue_pulse, [10] request_pending, [15:11] zero
	output logic [15:0]        m_tdata,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_D_W-1:0] cfg_wdata
);

	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_STATES);

	gfsm_item_t       item_s1;
	logic             valid_s1;
	gfsm_result_t     res_s2;
	logic             valid_s2;
	gfsm_ctx_t        ctx_q;
	gfsm_cfg_t        cfg_q;
	logic [CNT_W-1:0] count_q;

	logic             advance;
	logic [CNT_W-1:0] n_used;
	logic [SLOTS-1:0] in_use;
	gfsm_ctx_t        ctx_next;
	gfsm_result_t     result;
	logic             restart;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign n_used = (count_q == '0)   ? CNT_W'(1) :
			(count_q > MAX_N) ? MAX_N : count_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			in_use[i] = CNT_W'(i) < n_used;
		end
	end

	gfsm_step u_step (
		.item     (item_s1),
		.ctx      (ctx_q),
		.cfg      (cfg_q),
		.n_used   (n_used),
		.ctx_next (ctx_next),
		.result   (result),
		.restart  (restart)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation        <= gfsm_op_t'(s_tuser);
			item_s1.target_state     <= s_tdata[3:0];
			item_s1.current_finished <= s_tdata[4];
			item_s1.current_exit_ok  <= s_tdata[5];
			item_s1.entry_ok_mask    <= s_tdata[21:6];
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// Settings; a write wins over a restart, which otherwise re-enables everything in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q                      <= CNT_W'(1);
			cfg_q.global_enable          <= 1'b1;
			cfg_q.target_enable_mask     <= '1;
			cfg_q.successor_table        <= '0;
			cfg_q.successor_present_mask <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_STATE_COUNT:   count_q <= cfg_wdata[CNT_W-1:0];
				CFG_GLOBAL_ENABLE: cfg_q.global_enable <= cfg_wdata[0];
				CFG_TARGET_ENABLE: cfg_q.target_enable_mask <= cfg_wdata[SLOTS-1:0];
				CFG_SUCC_TABLE:    cfg_q.successor_table <= cfg_wdata;
				CFG_SUCC_PRESENT:  cfg_q.successor_present_mask <= cfg_wdata[SLOTS-1:0];
				default: begin
				end
			endcase
		end else if (advance && restart) begin
			cfg_q.global_enable      <= 1'b1;
			cfg_q.target_enable_mask <= cfg_q.target_enable_mask | in_use;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.request_pending, res_s2.continue_pulse,
			   res_s2.init_pulse, res_s2.exit_pulse, res_s2.event_code,
			   res_s2.current_index};

	a_transition_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_code == EV_TRANSITION) |->
		(res_s2.exit_pulse && res_s2.init_pulse))
		else $error("transition result without exit and init pulses");

	a_empty_output_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input blocked while the result register is empty");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.operation == OP_RESTART) |=>
		(ctx_q.started && ctx_q.present_state == '0))
		else $error("restart did not make state zero current");

	a_pending_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctx_q.pending_valid) |->
		$past(advance && item_s1.operation == OP_REQUEST))
		else $error("pending request appeared without a request item");

endmodule
